>>> design/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue package
// Operation and status codes, and the command and status structs that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_POP     = 2'd1;
   localparam logic [1:0] OP_UPGRADE = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_EMPTY      = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
   localparam logic [2:0] ST_NOT_URGENT = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic do_insert;
      logic do_pop;
      logic do_upgrade;
      logic do_clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_full;
      logic is_empty;
      logic id_found;
      logic more_urgent;
   } stat_type;

endpackage

>>> design/spq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// One request moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface spq_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue controller
// Decodes the request against the datapath status, issues the update command
// and picks the response status code.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic [1:0]        operation,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd,
   output logic [2:0]        status_in
);

   // Two states: the controller never holds off a request; this bit tracks
   // whether a response has ever been issued since reset.
   localparam logic S_IDLE = 1'b0;
   localparam logic S_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state_in = (req_fire || state_ff == S_RUN) ? S_RUN : S_IDLE;

   // Decode the operation into a command and a status code.
   always_comb begin
      cmd       = '0;
      status_in = spq_pkg::ST_OK;
      unique case (operation)
         spq_pkg::OP_INSERT: begin
            if (stat.is_full) begin
               status_in = spq_pkg::ST_FULL;
            end else begin
               cmd.do_insert = req_fire;
            end
         end
         spq_pkg::OP_POP: begin
            if (stat.is_empty) begin
               status_in = spq_pkg::ST_EMPTY;
            end else begin
               cmd.do_pop = req_fire;
            end
         end
         spq_pkg::OP_UPGRADE: begin
            priority if (stat.is_empty) begin
               status_in = spq_pkg::ST_EMPTY;
            end else if (!stat.id_found) begin
               status_in = spq_pkg::ST_NOT_FOUND;
            end else if (!stat.more_urgent) begin
               status_in = spq_pkg::ST_NOT_URGENT;
            end else begin
               cmd.do_upgrade = req_fire;
            end
         end
         default: begin
            cmd.do_clear = req_fire;
         end
      endcase
   end

endmodule

>>> design/spq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue datapath
// A sorted shift-register array of slots. Every slot compares itself with the
// request in parallel and decides to hold, shift back, shift forward or load.
// ----------------------------------------------------------------------------
module spq_dp #(
   parameter int unsigned CAPACITY      = 16,
   parameter int unsigned PRIORITY_BITS = 16,
   parameter int unsigned ID_BITS       = 16,
   parameter int unsigned CNT_W         = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spq_pkg::cmd_type         cmd,
   input  logic [ID_BITS-1:0]       id_req,
   input  logic [PRIORITY_BITS-1:0] pri_req,
   output spq_pkg::stat_type        stat,
   output logic [ID_BITS-1:0]       head_id,
   output logic [PRIORITY_BITS-1:0] head_pri,
   output logic [ID_BITS-1:0]       head_id_now,
   output logic [CNT_W-1:0]         count
);

   logic [ID_BITS-1:0]       id_ff  [CAPACITY];
   logic [PRIORITY_BITS-1:0] pri_ff [CAPACITY];
   logic [CAPACITY-1:0]      valid_ff;
   logic [CNT_W-1:0]         count_ff;

   logic [CAPACITY-1:0] gt;      // slot priority greater than request
   logic [CAPACITY-1:0] match;   // slot id equals request
   logic [CAPACITY-1:0] first;   // first matching slot
   logic [CAPACITY-1:0] ahead;   // slots strictly ahead of the first match
   logic [CAPACITY-1:0] ins_at;  // insertion position
   logic [CAPACITY-1:0] behind;  // slots at or behind insertion position
   logic                urgent;

   // Parallel compares on every slot.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         gt[i]    = valid_ff[i] && (pri_ff[i] > pri_req);
         match[i] = valid_ff[i] && (id_ff[i] == id_req);
      end
   end

   // One-hot first match, and the insertion point as first greater slot
   // (or the first free slot when none is greater).
   always_comb begin
      first = match & ~(match - CAPACITY'(1));
      ahead = first - CAPACITY'(1);
      if (match == '0) begin
         ahead = '1;
      end
      // gt is a prefix-free run under sorting: ones from some point to count.
      behind = gt | ~valid_ff;
      ins_at = behind & ~(behind - CAPACITY'(1));
      urgent = |(first & gt);
   end

   assign stat.is_full     = valid_ff[CAPACITY-1];
   assign stat.is_empty    = !valid_ff[0];
   assign stat.id_found    = |match;
   assign stat.more_urgent = urgent;

   // Slot update: each slot picks its next value from itself or a neighbour.
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (cmd.do_pop) begin
            if (i < CAPACITY - 1) begin
               id_ff[i]  <= id_ff[i+1];
               pri_ff[i] <= pri_ff[i+1];
            end
         end else if (cmd.do_insert || (cmd.do_upgrade && ahead[i])) begin
            if (ins_at[i]) begin
               id_ff[i]  <= id_req;
               pri_ff[i] <= pri_req;
            end else if (behind[i] && i > 0) begin
               id_ff[i]  <= id_ff[(i > 0) ? i - 1 : 0];
               pri_ff[i] <= pri_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (cmd.do_upgrade && first[i]) begin
            // The matched slot takes its neighbour, or the request if the
            // insertion point lands on it.
            if (ins_at[i]) begin
               pri_ff[i] <= pri_req;
            end else if (i > 0) begin
               id_ff[i]  <= id_ff[(i > 0) ? i - 1 : 0];
               pri_ff[i] <= pri_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end
   end

   // Occupancy as a thermometer of valid bits plus a count.
   always_ff @(posedge clock) begin
      if (reset || cmd.do_clear) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.do_insert) begin
         valid_ff <= {valid_ff[CAPACITY-2:0], 1'b1};
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.do_pop) begin
         valid_ff <= {1'b0, valid_ff[CAPACITY-1:1]};
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   assign head_id     = valid_ff[0] ? id_ff[0] : '0;
   assign head_pri    = valid_ff[0] ? pri_ff[0] : '0;
   assign head_id_now = id_ff[0];
   assign count       = count_ff;

endmodule

>>> design/stable_priority_queue_decrease_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue with decrease-key
// Top level: request and response channels around controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries an operation (insert, pop, upgrade, clear), an
//   identifier and a priority. Each request yields one response with the
//   status, the popped identifier, the front entry, emptiness and the count.
//   The slots form a sorted shift-register array; every slot compares with
//   the request in parallel, so an operation completes at the accepting
//   edge. The response is registered and appears the cycle after
//   acceptance; one request per cycle while the receiver keeps up.
//   A new request is taken while the response register is empty or being
//   read in the same cycle; when the receiver stalls, the response holds and
//   req_ready stays low until it is taken.
//   Reset empties the queue and the response register; slot contents are
//   not cleared, only their valid bits.
// ----------------------------------------------------------------------------
module stable_priority_queue_decrease_key #(
   parameter int unsigned CAPACITY      = 16,
   parameter int unsigned PRIORITY_BITS = 16,
   parameter int unsigned ID_BITS       = 16
) (
   input  logic   clock,
   input  logic   reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   input  logic [15:0]          req_patient_id,
   input  logic [15:0]          req_priority_req,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [15:0]          rsp_popped_id,
   output logic [15:0]          rsp_front_id,
   output logic [15:0]          rsp_front_priority,
   output logic                 rsp_is_empty,
   output logic [4:0]           rsp_entry_count
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   spq_pkg::cmd_type  cmd;
   spq_pkg::stat_type stat;
   logic [2:0]               status_in;
   logic [ID_BITS-1:0]       head_id;
   logic [ID_BITS-1:0]       head_id_now;
   logic [PRIORITY_BITS-1:0] head_pri;
   logic [CNT_W-1:0]         count;
   logic                     req_fire;

   logic                     rsp_valid_ff;
   logic [2:0]               status_ff;
   logic [15:0]              popped_ff;
   logic                     popped_ff_en;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .operation (req_operation),
      .stat      (stat),
      .cmd       (cmd),
      .status_in (status_in)
   );

   spq_dp #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIORITY_BITS),
      .ID_BITS       (ID_BITS),
      .CNT_W         (CNT_W)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .id_req      (req_patient_id[ID_BITS-1:0]),
      .pri_req     (req_priority_req[PRIORITY_BITS-1:0]),
      .stat        (stat),
      .head_id     (head_id),
      .head_pri    (head_pri),
      .head_id_now (head_id_now),
      .count       (count)
   );

   assign popped_ff_en = cmd.do_pop;

   // Response register; the front and count come live from the slots, which
   // only change when a request is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_in;
         popped_ff <= popped_ff_en ? 16'(head_id_now) : 16'd0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_popped_id      = popped_ff;
   assign rsp_front_id       = 16'(head_id);
   assign rsp_front_priority = 16'(head_pri);
   assign rsp_is_empty       = (count == '0);
   assign rsp_entry_count    = 5'(count);

   // A pending response is held while the receiver stalls.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response changed while stalled");

   // A pop only ever happens on a non-empty queue.
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_pop |-> count != '0)
      else $error("pop of empty queue");

   // An insert never overfills the queue.
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |=> count != '0 && $past(count) != CNT_W'(CAPACITY))
      else $error("insert into full queue");

endmodule

>>> bench/spq_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue bench types
// Request and response payloads carried on the bench channels.
// ----------------------------------------------------------------------------
package spq_tb_pkg;

   // One request to the queue.
   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] patient_id;
      logic [15:0] priority_req;
   } queue_req_type;

   // One response from the queue.
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] popped_id;
      logic [15:0] front_id;
      logic [15:0] front_priority;
      logic        is_empty;
      logic [4:0]  entry_count;
   } queue_rsp_type;

endpackage

>>> bench/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue checker
// Watches both channels, keeps its own sorted copy of the queue, predicts the
// response to every accepted request and compares responses in order.
// ----------------------------------------------------------------------------
module spq_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  spq_tb_pkg::queue_req_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  spq_tb_pkg::queue_rsp_type rsp_payload,
   output int                        pending_count,
   output int                        error_count
);

   localparam int DEPTH = 16;

   logic [15:0]               held_id  [DEPTH];
   logic [15:0]               held_pri [DEPTH];
   int                        held_n;
   spq_tb_pkg::queue_rsp_type expected_rsps[$];

   // Applies one request to the shadow queue and returns the response it gives.
   function automatic spq_tb_pkg::queue_rsp_type apply_request(
      spq_tb_pkg::queue_req_type r);
      spq_tb_pkg::queue_rsp_type res;
      int pos;
      int k;
      res = '0;
      res.status = spq_pkg::ST_OK;
      case (r.operation)
         spq_pkg::OP_INSERT: begin
            if (held_n >= DEPTH) begin
               res.status = spq_pkg::ST_FULL;
            end else begin
               pos = held_n;
               for (int i = held_n - 1; i >= 0; i--)
                  if (held_pri[i] > r.priority_req) pos = i;
               for (int i = held_n; i > pos; i--) begin
                  held_id[i]  = held_id[i-1];
                  held_pri[i] = held_pri[i-1];
               end
               held_id[pos]  = r.patient_id;
               held_pri[pos] = r.priority_req;
               held_n++;
            end
         end
         spq_pkg::OP_POP: begin
            if (held_n == 0) begin
               res.status = spq_pkg::ST_EMPTY;
            end else begin
               res.popped_id = held_id[0];
               for (int i = 1; i < held_n; i++) begin
                  held_id[i-1]  = held_id[i];
                  held_pri[i-1] = held_pri[i];
               end
               held_n--;
            end
         end
         spq_pkg::OP_UPGRADE: begin
            if (held_n == 0) begin
               res.status = spq_pkg::ST_EMPTY;
            end else begin
               k = held_n;
               for (int i = held_n - 1; i >= 0; i--)
                  if (held_id[i] == r.patient_id) k = i;
               if (k == held_n) begin
                  res.status = spq_pkg::ST_NOT_FOUND;
               end else if (r.priority_req >= held_pri[k]) begin
                  res.status = spq_pkg::ST_NOT_URGENT;
               end else begin
                  // The entry moves forward, behind any of equal priority.
                  pos = k;
                  for (int i = k - 1; i >= 0; i--)
                     if (held_pri[i] > r.priority_req) pos = i;
                  for (int i = k; i > pos; i--) begin
                     held_id[i]  = held_id[i-1];
                     held_pri[i] = held_pri[i-1];
                  end
                  held_id[pos]  = r.patient_id;
                  held_pri[pos] = r.priority_req;
               end
            end
         end
         default: held_n = 0;
      endcase
      if (held_n > 0) begin
         res.front_id       = held_id[0];
         res.front_priority = held_pri[0];
      end
      res.is_empty    = (held_n == 0);
      res.entry_count = held_n[4:0];
      return res;
   endfunction

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   initial begin
      error_count = 0;
      held_n = 0;
   end

   assign pending_count = expected_rsps.size();

   // Responses are compared against the oldest expectation, then any new
   // request accepted at the same edge is predicted.
   always @(posedge clock) begin
      spq_tb_pkg::queue_rsp_type exp_r;
      if (reset) begin
         held_n = 0;
         expected_rsps.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("Response with no request outstanding");
               error_count++;
            end else begin
               exp_r = expected_rsps.pop_front();
               check_field("status", exp_r.status, rsp_payload.status);
               check_field("popped_id", exp_r.popped_id, rsp_payload.popped_id);
               check_field("front_id", exp_r.front_id, rsp_payload.front_id);
               check_field("front_priority", exp_r.front_priority,
                           rsp_payload.front_priority);
               check_field("is_empty", exp_r.is_empty, rsp_payload.is_empty);
               check_field("entry_count", exp_r.entry_count, rsp_payload.entry_count);
            end
         end
         if (req_valid && req_ready)
            expected_rsps.push_back(apply_request(req_payload));
      end
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue testbench
// Drives directed and random queue requests with random gaps and stalls on
// both channels; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_REQS = 850;

   logic clock;
   logic reset;
   logic req_ready_s;
   logic long_hold_due;
   int   pending_count;
   int   error_count;
   int   quiet_mode;

   spq_if #(.payload_type(spq_tb_pkg::queue_req_type)) req_ch ();
   spq_if #(.payload_type(spq_tb_pkg::queue_rsp_type)) rsp_ch ();

   stable_priority_queue_decrease_key DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_ch.valid),
      .req_ready          (req_ch.ready),
      .req_operation      (req_ch.payload.operation),
      .req_patient_id     (req_ch.payload.patient_id),
      .req_priority_req   (req_ch.payload.priority_req),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_status         (rsp_ch.payload.status),
      .rsp_popped_id      (rsp_ch.payload.popped_id),
      .rsp_front_id       (rsp_ch.payload.front_id),
      .rsp_front_priority (rsp_ch.payload.front_priority),
      .rsp_is_empty       (rsp_ch.payload.is_empty),
      .rsp_entry_count    (rsp_ch.payload.entry_count)
   );

   spq_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_payload   (req_ch.payload),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_payload   (rsp_ch.payload),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   // Clock, 12 ns period.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Ready is sampled mid-cycle so the sender sees the value before the edge.
   always @(negedge clock) req_ready_s = req_ch.ready;

   // Mostly short gaps, a few long ones, none at all in quiet stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode != 0) return 0;
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // Offers one request and waits for it to be accepted.
   task automatic send_request(logic [1:0] op, logic [15:0] id, logic [15:0] pri);
      int gap;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= '{operation: op, patient_id: id, priority_req: pri};
      @(posedge clock);
      while (!req_ready_s) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Identifiers mostly from a small pool so upgrades find entries.
   function automatic logic [15:0] pick_id();
      if ($urandom_range(0, 9) < 8) return 16'($urandom_range(0, 11));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_priority();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 16'($urandom_range(0, 20));
      if (r < 8) return 16'($urandom_range(65515, 65535));
      return 16'($urandom);
   endfunction

   // Response side: random ready bursts, with one long hold-off on demand.
   initial begin
      int on_len;
      int off_len;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold_due) begin
            rsp_ch.ready <= 1'b0;
            repeat (80) @(posedge clock);
            long_hold_due = 1'b0;
         end
         rsp_ch.ready <= 1'b1;
         on_len = $urandom_range(1, 20);
         repeat (on_len) @(posedge clock);
         off_len = pick_gap();
         if (off_len > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int r;
      logic [1:0] op;
      long_hold_due = 1'b0;
      quiet_mode = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: operations on an empty queue.
      send_request(spq_pkg::OP_POP, 16'h0000, 16'h0000);
      send_request(spq_pkg::OP_UPGRADE, 16'h0001, 16'h0000);
      send_request(spq_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
      // Single entry upgraded to an equal priority is not more urgent.
      send_request(spq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF);
      send_request(spq_pkg::OP_UPGRADE, 16'hFFFF, 16'hFFFF);
      // Ties leave in arrival order; duplicates act on the nearest one.
      send_request(spq_pkg::OP_INSERT, 16'h0005, 16'h0010);
      send_request(spq_pkg::OP_INSERT, 16'h0006, 16'h0010);
      send_request(spq_pkg::OP_INSERT, 16'h0005, 16'h0020);
      send_request(spq_pkg::OP_UPGRADE, 16'h0005, 16'h0011);
      send_request(spq_pkg::OP_UPGRADE, 16'h1234, 16'h0000);
      send_request(spq_pkg::OP_UPGRADE, 16'hFFFF, 16'h0010);
      send_request(spq_pkg::OP_INSERT, 16'h0000, 16'h0000);
      send_request(spq_pkg::OP_UPGRADE, 16'h0006, 16'h0000);
      send_request(spq_pkg::OP_POP, 16'h0000, 16'h0000);
      // Fill to capacity, then one more insert is refused.
      for (int i = 0; i < 12; i++)
         send_request(spq_pkg::OP_INSERT, 16'(16'hA000 + i), 16'(i % 3));
      send_request(spq_pkg::OP_INSERT, 16'h5555, 16'hAAAA);
      send_request(spq_pkg::OP_POP, 16'h0000, 16'h0000);
      send_request(spq_pkg::OP_CLEAR, 16'h0000, 16'h0000);

      // Random traffic, weighted so the queue spends time nearly full.
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n % 100 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
         if (n == 200) long_hold_due = 1'b1;
         if (n == 450) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 45) op = spq_pkg::OP_INSERT;
         else if (r < 72) op = spq_pkg::OP_POP;
         else if (r < 98) op = spq_pkg::OP_UPGRADE;
         else op = spq_pkg::OP_CLEAR;
         send_request(op, pick_id(), pick_priority());
      end

      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog.
   initial begin
      #(12 * 500000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
design/spq_pkg.sv
design/spq_if.sv
design/spq_ctrl.sv
design/spq_dp.sv
design/stable_priority_queue_decrease_key.sv
bench/spq_tb_pkg.sv
bench/spq_checker.sv
bench/tb_top.sv
